### sv/gbnr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbnr_pkg: shared types and constants of the go-back-n session check
// Field widths, verdict codes, the query item that walks the cell chain,
// the append command and the controller states.
// ----------------------------------------------------------------------------
package gbnr_pkg;

    localparam int ADDR_W    = 8;
    localparam int PORT_W    = 14;
    localparam int SEQ_W     = 16;
    localparam int WIN_W     = 15;
    localparam int VERDICT_W = 3;
    localparam int COUNT_W   = 5;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 15'd8;

    // verdict codes
    localparam logic [VERDICT_W-1:0] V_IN_ORDER  = 3'd0;
    localparam logic [VERDICT_W-1:0] V_DUPLICATE = 3'd1;
    localparam logic [VERDICT_W-1:0] V_BAD_SEQ   = 3'd2;
    localparam logic [VERDICT_W-1:0] V_UNKNOWN   = 3'd3;
    localparam logic [VERDICT_W-1:0] V_FULL      = 3'd4;

    // query item handed from cell to cell
    typedef struct packed {
        logic                 valid;
        logic [ADDR_W-1:0]    addr;
        logic [PORT_W-1:0]    port;
        logic [SEQ_W-1:0]     seq;
        logic                 found;
        logic [VERDICT_W-1:0] verdict;
    } t_token;

    // append of a new session into the cell at the current count
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
    } t_load;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

endpackage
`default_nettype wire

### sv/gbnr_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbnr_cell: one session slot of the chain
// Holds address, port and expected sequence number of one session. Checks
// the passing query item against its session, updates the expected number
// on a hit and hands the item to the next cell in the next cycle.
// ----------------------------------------------------------------------------
module gbnr_cell #(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 5
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [CNT_W-1:0]            i_count,
    input  wire logic [gbnr_pkg::WIN_W-1:0]  i_window,
    input  wire gbnr_pkg::t_load             i_load,
    input  wire gbnr_pkg::t_token            i_tok,
    output gbnr_pkg::t_token                 o_tok
);

    logic [gbnr_pkg::ADDR_W-1:0] r_addr;
    logic [gbnr_pkg::PORT_W-1:0] r_port;
    logic [gbnr_pkg::SEQ_W-1:0]  r_exp;
    logic [gbnr_pkg::SEQ_W-1:0]  n_exp;
    gbnr_pkg::t_token            r_tok;
    gbnr_pkg::t_token            n_tok;

    logic                        occupied;
    logic                        hit;
    logic                        sel;
    logic [gbnr_pkg::SEQ_W-1:0]  behind;

    // slot is live when its index lies below the session count
    assign occupied = CNT_W'(CELL_IDX) < i_count;
    assign sel      = i_load.en && (i_count == CNT_W'(CELL_IDX));
    assign hit      = i_tok.valid && !i_tok.found && occupied
                      && (r_addr == i_tok.addr) && (r_port == i_tok.port);
    assign behind   = r_exp - i_tok.seq;

    // classify the sequence number against the expected one
    always_comb begin
        n_tok = i_tok;
        n_exp = r_exp;
        if (hit) begin
            n_tok.found = 1'b1;
            if (i_tok.seq == r_exp) begin
                n_tok.verdict = gbnr_pkg::V_IN_ORDER;
                n_exp         = r_exp + gbnr_pkg::SEQ_W'(1);
            end else if (behind < {1'b0, i_window}) begin
                n_tok.verdict = gbnr_pkg::V_DUPLICATE;
            end else if (i_tok.seq == '0) begin
                n_tok.verdict = gbnr_pkg::V_IN_ORDER;
                n_exp         = gbnr_pkg::SEQ_W'(1);
            end else begin
                n_tok.verdict = gbnr_pkg::V_BAD_SEQ;
            end
        end
    end

    // session contents
    always_ff @(posedge i_clk) begin
        if (sel) begin
            r_addr <= i_load.addr;
            r_port <= i_load.port;
            r_exp  <= gbnr_pkg::SEQ_W'(1);
        end else begin
            r_exp  <= n_exp;
        end
    end

    // item stage toward the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

### sv/go_back_n_receiver_session_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// go_back_n_receiver_session_check: session lookup and sequence check
// Finds the session of a received packet header in a chain of session
// cells, classifies its sequence number and appends new sessions.
// ----------------------------------------------------------------------------
// Usage:
// - input channel i_in_valid / o_in_ready carries one header item: source
//   address, port and sequence number
// - output channel o_out_valid / i_out_ready returns one verdict item per
//   header, with the session count after that header
// - i_cfg_valid / o_cfg_ready writes the window size; write it only while
//   no header is in flight (o_cfg_ready is always high)
// - a header enters cell 0 and moves one cell per cycle; the first live
//   cell that matches address and port decides the verdict
// - one header item at a time: a header walks the whole cell chain and is
//   registered at the chain end, and its verdict is registered before the
//   next header is accepted
// - the next header is accepted while a verdict still waits in the output
//   register; when the receiver stalls, the following finished header waits
//   at the chain end and no new header is taken
// - reset empties the session table (count zero) and sets the window to 8
// ----------------------------------------------------------------------------
module go_back_n_receiver_session_check #(
    parameter int MAX_SESSIONS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [gbnr_pkg::WIN_W-1:0]      i_cfg_window_size,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [gbnr_pkg::ADDR_W-1:0]     i_source_address,
    input  wire logic [gbnr_pkg::PORT_W-1:0]     i_port_number,
    input  wire logic [gbnr_pkg::SEQ_W-1:0]      i_sequence_number,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [gbnr_pkg::VERDICT_W-1:0]       o_verdict,
    output logic [gbnr_pkg::COUNT_W-1:0]         o_session_count
);

    localparam int CNT_W = $clog2(MAX_SESSIONS + 1);

    gbnr_pkg::t_state                  r_state;
    gbnr_pkg::t_state                  n_state;
    logic [gbnr_pkg::WIN_W-1:0]        r_window;
    logic [CNT_W-1:0]                  r_count;
    logic [CNT_W-1:0]                  n_count;
    gbnr_pkg::t_token                  r_fin;
    gbnr_pkg::t_token                  n_fin;
    logic                              r_out_valid;
    logic                              n_out_valid;
    logic [gbnr_pkg::VERDICT_W-1:0]    r_out_verdict;
    logic [gbnr_pkg::VERDICT_W-1:0]    n_out_verdict;
    logic [CNT_W-1:0]                  r_out_count;
    logic [CNT_W-1:0]                  n_out_count;
    gbnr_pkg::t_load                   load;
    gbnr_pkg::t_token                  w_tok [MAX_SESSIONS+1];

    assign o_cfg_ready = 1'b1;

    // window register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= gbnr_pkg::WINDOW_RESET;
        end else if (i_cfg_valid) begin
            r_window <= i_cfg_window_size;
        end
    end

    // item entering the chain
    always_comb begin
        w_tok[0].valid   = i_in_valid && o_in_ready;
        w_tok[0].addr    = i_source_address;
        w_tok[0].port    = i_port_number;
        w_tok[0].seq     = i_sequence_number;
        w_tok[0].found   = 1'b0;
        w_tok[0].verdict = gbnr_pkg::V_UNKNOWN;
    end

    // chain of session cells
    for (genvar g = 0; g < MAX_SESSIONS; g++) begin : g_cell
        gbnr_cell #(
            .CELL_IDX (g),
            .CNT_W    (CNT_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_count  (r_count),
            .i_window (r_window),
            .i_load   (load),
            .i_tok    (w_tok[g]),
            .o_tok    (w_tok[g+1])
        );
    end

    // controller: next state, append and output register
    always_comb begin
        n_state       = r_state;
        n_fin         = r_fin;
        n_count       = r_count;
        n_out_valid   = r_out_valid;
        n_out_verdict = r_out_verdict;
        n_out_count   = r_out_count;
        load.en       = 1'b0;
        load.addr     = r_fin.addr;
        load.port     = r_fin.port;
        o_in_ready    = (r_state == gbnr_pkg::S_IDLE);
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            gbnr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = gbnr_pkg::S_SCAN;
                end
            end
            gbnr_pkg::S_SCAN: begin
                if (w_tok[MAX_SESSIONS].valid) begin
                    n_fin   = w_tok[MAX_SESSIONS];
                    n_state = gbnr_pkg::S_FIN;
                end
            end
            gbnr_pkg::S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_state     = gbnr_pkg::S_IDLE;
                    if (r_fin.found) begin
                        n_out_verdict = r_fin.verdict;
                    end else if (r_fin.seq != '0) begin
                        n_out_verdict = gbnr_pkg::V_UNKNOWN;
                    end else if (r_count >= CNT_W'(MAX_SESSIONS)) begin
                        n_out_verdict = gbnr_pkg::V_FULL;
                    end else begin
                        n_out_verdict = gbnr_pkg::V_IN_ORDER;
                        load.en       = 1'b1;
                        n_count       = r_count + CNT_W'(1);
                    end
                    n_out_count = n_count;
                end
            end
            default: begin
                n_state = gbnr_pkg::S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbnr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_fin         <= n_fin;
        r_out_verdict <= n_out_verdict;
        r_out_count   <= n_out_count;
    end

    assign o_out_valid     = r_out_valid;
    assign o_verdict       = r_out_verdict;
    assign o_session_count = gbnr_pkg::COUNT_W'(r_out_count);

endmodule
`default_nettype wire

### tb/go_back_n_receiver_session_check_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_back_n_receiver_session_check_tb: self-checking bench of the session check
// Keeps its own copy of the session table and the window, predicts the verdict
// and session count of every accepted header item and compares them with the
// block's result items. Both channels idle at random, the window is rewritten
// between phases, and a watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------

// session table copy, window copy and the verdicts still owed by the block
class session_verdicts;
    int                             slots;
    int                             stored;
    int                             errors;
    logic [gbnr_pkg::WIN_W-1:0]     window;
    logic [gbnr_pkg::ADDR_W-1:0]    addr_tab [256];
    logic [gbnr_pkg::PORT_W-1:0]    port_tab [256];
    logic [gbnr_pkg::SEQ_W-1:0]     next_seq_tab [256];
    logic [gbnr_pkg::VERDICT_W-1:0] verdict_q [$];
    logic [gbnr_pkg::COUNT_W-1:0]   count_q [$];

    function new(int max_sessions);
        slots  = max_sessions;
        stored = 0;
        errors = 0;
        window = gbnr_pkg::WINDOW_RESET;
    endfunction

    // classify one accepted header and update the table
    function void note_header(logic [gbnr_pkg::ADDR_W-1:0] addr,
                              logic [gbnr_pkg::PORT_W-1:0] port,
                              logic [gbnr_pkg::SEQ_W-1:0] seq);
        int                             slot;
        int                             i;
        logic [gbnr_pkg::SEQ_W-1:0]     behind;
        logic [gbnr_pkg::VERDICT_W-1:0] verdict;
        slot = -1;
        i    = 0;
        // first stored session with the same address and port
        while (slot < 0 && i < stored) begin
            if (addr_tab[i] == addr && port_tab[i] == port) slot = i;
            i++;
        end
        if (slot >= 0) begin
            behind = next_seq_tab[slot] - seq;
            if (seq == next_seq_tab[slot]) begin
                next_seq_tab[slot] = seq + 1'b1;
                verdict = gbnr_pkg::V_IN_ORDER;
            end else if (behind != '0 && int'(behind) < int'(window)) begin
                verdict = gbnr_pkg::V_DUPLICATE;
            end else if (seq == '0) begin
                // restart of a known session
                next_seq_tab[slot] = 16'd1;
                verdict = gbnr_pkg::V_IN_ORDER;
            end else begin
                verdict = gbnr_pkg::V_BAD_SEQ;
            end
        end else if (seq != '0) begin
            verdict = gbnr_pkg::V_UNKNOWN;
        end else if (stored >= slots) begin
            verdict = gbnr_pkg::V_FULL;
        end else begin
            // new session appended at the end of the table
            addr_tab[stored]     = addr;
            port_tab[stored]     = port;
            next_seq_tab[stored] = 16'd1;
            stored++;
            verdict = gbnr_pkg::V_IN_ORDER;
        end
        verdict_q.push_back(verdict);
        count_q.push_back(stored[gbnr_pkg::COUNT_W-1:0]);
    endfunction

    // compare one accepted result item with the oldest prediction
    function void check_verdict(logic [gbnr_pkg::VERDICT_W-1:0] verdict,
                                logic [gbnr_pkg::COUNT_W-1:0] count);
        logic [gbnr_pkg::VERDICT_W-1:0] want_verdict;
        logic [gbnr_pkg::COUNT_W-1:0]   want_count;
        if (verdict_q.size() == 0) begin
            $display("%0t: result item with no header pending: verdict %0d count %0d",
                     $time, verdict, count);
            errors++;
        end else begin
            want_verdict = verdict_q.pop_front();
            want_count   = count_q.pop_front();
            if (verdict !== want_verdict) begin
                $display("%0t: verdict mismatch: expected %0d, actual %0d",
                         $time, want_verdict, verdict);
                errors++;
            end
            if (count !== want_count) begin
                $display("%0t: session count mismatch: expected %0d, actual %0d",
                         $time, want_count, count);
                errors++;
            end
        end
    endfunction

    function int pending();
        return verdict_q.size();
    endfunction
endclass

module go_back_n_receiver_session_check_tb;

    localparam int SESSIONS     = 16;
    localparam int POOL         = 20;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = SESSIONS + 3;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [gbnr_pkg::WIN_W-1:0]     i_cfg_window_size;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic [gbnr_pkg::ADDR_W-1:0]    i_source_address;
    logic [gbnr_pkg::PORT_W-1:0]    i_port_number;
    logic [gbnr_pkg::SEQ_W-1:0]     i_sequence_number;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic [gbnr_pkg::VERDICT_W-1:0] o_verdict;
    logic [gbnr_pkg::COUNT_W-1:0]   o_session_count;

    session_verdicts                sessions;
    logic                           quiet_in;
    logic                           quiet_out;
    int                             idle_cycles = 0;
    logic [gbnr_pkg::ADDR_W-1:0]    pool_addr [POOL];
    logic [gbnr_pkg::PORT_W-1:0]    pool_port [POOL];

    go_back_n_receiver_session_check #(
        .MAX_SESSIONS(SESSIONS)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_window_size (i_cfg_window_size),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_source_address  (i_source_address),
        .i_port_number     (i_port_number),
        .i_sequence_number (i_sequence_number),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_verdict         (o_verdict),
        .o_session_count   (o_session_count)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // accepted items on all three channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sessions.window = i_cfg_window_size;
            if (o_out_valid && i_out_ready) sessions.check_verdict(o_verdict, o_session_count);
            if (i_in_valid && o_in_ready) begin
                sessions.note_header(i_source_address, i_port_number, i_sequence_number);
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready)
            || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("go_back_n_receiver_session_check test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stall before each item
    initial begin
        int stall;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = quiet_out ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // one header item, after a random gap
    task automatic send_header(input logic [gbnr_pkg::ADDR_W-1:0] addr,
                               input logic [gbnr_pkg::PORT_W-1:0] port,
                               input logic [gbnr_pkg::SEQ_W-1:0] seq);
        int gap;
        gap = quiet_in ? 0 : $urandom_range(0, 11);
        if (gap > 0) repeat (gap) @(negedge i_clk);
        i_source_address  = addr;
        i_port_number     = port;
        i_sequence_number = seq;
        i_in_valid        = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // window write once every verdict is back
    task automatic write_window(input logic [gbnr_pkg::WIN_W-1:0] size);
        while (sessions.pending() != 0) @(negedge i_clk);
        i_cfg_window_size = size;
        i_cfg_valid       = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // mostly known sessions with sequence numbers around the expected one
    task automatic send_random_header();
        int                         pick;
        int                         idx;
        int                         off;
        int                         win;
        logic [gbnr_pkg::SEQ_W-1:0] seq;
        pick = $urandom_range(0, 99);
        win  = int'(sessions.window);
        if (pick < 65 && sessions.stored > 0) begin
            idx  = $urandom_range(0, sessions.stored - 1);
            seq  = sessions.next_seq_tab[idx];
            pick = $urandom_range(0, 99);
            if (pick >= 45 && pick < 65) begin
                // behind the expected number, window edges included
                off = ($urandom_range(0, 3) == 0) ? win : $urandom_range(1, win + 1);
                seq = seq - off[gbnr_pkg::SEQ_W-1:0];
            end else if (pick >= 65 && pick < 75) begin
                seq = '0;
            end else if (pick >= 75 && pick < 85) begin
                seq = seq + $urandom_range(1, 64);
            end else if (pick >= 85) begin
                seq = $urandom;
            end
            send_header(sessions.addr_tab[idx], sessions.port_tab[idx], seq);
        end else if (pick < 85) begin
            // session start from the pool, new or already known
            idx = $urandom_range(0, POOL - 1);
            send_header(pool_addr[idx], pool_port[idx], '0);
        end else begin
            send_header($urandom, $urandom, $urandom);
        end
    endtask

    // random phase, idling switched off now and then
    task automatic run_random(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            if (n % 50 == 0) begin
                quiet_in  = ($urandom_range(0, 3) == 0);
                quiet_out = ($urandom_range(0, 3) == 0);
            end
            send_random_header();
        end
    endtask

    initial begin
        int k;
        sessions          = new(SESSIONS);
        i_rst_n           = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_window_size = '0;
        i_in_valid        = 1'b0;
        i_source_address  = '0;
        i_port_number     = '0;
        i_sequence_number = '0;
        quiet_in          = 1'b0;
        quiet_out         = 1'b0;
        pool_addr[0] = 8'hff;
        pool_port[0] = 14'h3fff;
        pool_addr[1] = 8'd0;
        pool_port[1] = 14'd0;
        pool_addr[2] = 8'd10;
        pool_port[2] = 14'd100;
        for (k = 3; k < POOL; k++) begin
            pool_addr[k] = $urandom;
            pool_port[k] = $urandom;
        end
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // unknown session, nonzero sequence
        send_header(8'd10, 14'd100, 16'd5);
        // new session and an in-order run
        send_header(8'd10, 14'd100, 16'd0);
        send_header(8'd10, 14'd100, 16'd1);
        send_header(8'd10, 14'd100, 16'd2);
        // a duplicate inside the window, an in-order number, a duplicate across the wrap
        send_header(8'd10, 14'd100, 16'd1);
        send_header(8'd10, 14'd100, 16'd3);
        send_header(8'd10, 14'd100, 16'hffff);
        // beyond the window
        send_header(8'd10, 14'd100, 16'd100);
        // extreme address and port
        send_header(8'hff, 14'h3fff, 16'd0);
        send_header(8'hff, 14'h3fff, 16'hffff);
        send_header(8'hff, 14'h3fff, 16'd1);
        send_header(8'd0, 14'd0, 16'd0);
        send_header(8'd0, 14'd0, 16'h8000);
        // restart once the window no longer covers zero
        write_window(15'd1);
        send_header(8'd10, 14'd100, 16'd0);
        send_header(8'd10, 14'd100, 16'd0);
        // zero window: nothing counts as a duplicate
        write_window('0);
        send_header(8'd10, 14'd100, 16'd0);
        send_header(8'hff, 14'h3fff, 16'd1);

        // random phases over several windows, extremes included
        write_window(15'd1);
        run_random(180);
        write_window(15'h7fff);
        run_random(180);
        write_window('0);
        run_random(150);
        write_window($urandom_range(2, 300));
        run_random(200);
        write_window($urandom_range(1, 32767));
        run_random(150);
        write_window(gbnr_pkg::WINDOW_RESET);
        run_random(140);

        // drain
        while (sessions.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sessions.errors == 0 && sessions.pending() == 0) begin
            $display("go_back_n_receiver_session_check test passed");
        end else begin
            $display("go_back_n_receiver_session_check test failed");
        end
        $finish;
    end

endmodule

### filelist.f
sv/gbnr_pkg.sv
sv/gbnr_cell.sv
sv/go_back_n_receiver_session_check.sv
tb/go_back_n_receiver_session_check_tb.sv
